[rtl/aftr_pkg.sv]
// Package for the accelerometer frame tilt receiver.
// Holds widths, sync codes, hunt codes, command struct and the CORDIC angle table.
// No dependencies.
package aftr_pkg;

    localparam int CordicSteps = 16;
    localparam int AngleFracBits = 7;
    localparam int StepW = $clog2(CordicSteps + 1);
    localparam int CordW = 28;   // sample*256 plus CORDIC growth
    localparam int AngW = 26;    // Q16 degrees, range +-512

    localparam logic [7:0] SyncFirst = 8'hA5;
    localparam logic [7:0] SyncSecond = 8'h5A;

    localparam logic [1:0] HuntWaitFirst = 2'd0;
    localparam logic [1:0] HuntWaitSecond = 2'd1;
    localparam logic [1:0] HuntBody = 2'd2;

    localparam logic signed [AngW-1:0] Deg90Q16 = AngW'(90 * 65536);
    localparam logic [16:0] InvGainQ16 = 17'd39797;

    typedef struct packed {
        logic load_roll;    // start roll pass from stored samples
        logic load_pitch;   // start pitch pass from magnitude
        logic iterate;      // one CORDIC micro-rotation
        logic save_roll;    // keep roll result and magnitude
        logic scale_mag;    // apply inverse gain to magnitude
        logic finish;       // pitch done, update smoother and result
    } t_cmd;

    function automatic logic signed [AngW-1:0] atan_q16(input logic [StepW-1:0] idx);
        case (idx)
            0: atan_q16 = AngW'(2949120);
            1: atan_q16 = AngW'(1740967);
            2: atan_q16 = AngW'(919879);
            3: atan_q16 = AngW'(466945);
            4: atan_q16 = AngW'(234379);
            5: atan_q16 = AngW'(117304);
            6: atan_q16 = AngW'(58666);
            7: atan_q16 = AngW'(29335);
            8: atan_q16 = AngW'(14668);
            9: atan_q16 = AngW'(7334);
            10: atan_q16 = AngW'(3667);
            11: atan_q16 = AngW'(1833);
            12: atan_q16 = AngW'(917);
            13: atan_q16 = AngW'(458);
            14: atan_q16 = AngW'(229);
            15: atan_q16 = AngW'(115);
            default: atan_q16 = '0;
        endcase
    endfunction

endpackage

[rtl/aftr_ctrl.sv]
// Controller: sync hunt, body byte counting and CORDIC sequencing.
// Depends on aftr_pkg.
module aftr_ctrl
    import aftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,       // byte transfer
    input  logic [7:0] i_byte,
    input  logic       i_out_busy,   // result register still full
    output logic       o_ready,
    output logic       o_store,      // write body byte
    output logic [2:0] o_store_idx,
    output t_cmd       o_cmd,
    output logic [StepW-1:0] o_step
);
    localparam logic [2:0] SIdle = 3'd0, SRoll = 3'd1, SScale = 3'd2,
                           SPitch = 3'd3, SLoadP = 3'd4, SFin = 3'd5;

    logic [1:0] r_hunt, n_hunt;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_st, n_st;
    logic [StepW-1:0] r_step, n_step;

    assign o_ready = (r_st == SIdle) && !i_out_busy;
    assign o_store = i_take && (r_hunt == HuntBody);
    assign o_store_idx = r_cnt[2:0];
    assign o_step = r_step;

    always_comb begin
        n_hunt = r_hunt;
        n_cnt = r_cnt;
        n_st = r_st;
        n_step = r_step;
        o_cmd = '0;
        case (r_st)
            SIdle: begin
                if (i_take) begin
                    case (r_hunt)
                        HuntWaitSecond: begin
                            if (i_byte == SyncSecond) begin
                                n_hunt = HuntBody;
                                n_cnt = '0;
                            end else if (i_byte != SyncFirst) begin
                                n_hunt = HuntWaitFirst;
                            end
                        end
                        HuntBody: begin
                            n_cnt = r_cnt + 4'd1;
                            if (r_cnt == 4'd7) begin
                                n_hunt = HuntWaitFirst;
                                n_cnt = '0;
                                n_st = SRoll;
                                n_step = '0;
                                o_cmd.load_roll = 1'b1;
                            end
                        end
                        default: n_hunt = (i_byte == SyncFirst) ? HuntWaitSecond
                                                                : HuntWaitFirst;
                    endcase
                end
            end
            SRoll: begin
                if (r_step == StepW'(CordicSteps)) begin
                    o_cmd.save_roll = 1'b1;
                    n_st = SScale;
                end else begin
                    o_cmd.iterate = 1'b1;
                    n_step = r_step + 1'b1;
                end
            end
            SScale: begin
                o_cmd.scale_mag = 1'b1;
                n_st = SLoadP;
            end
            SLoadP: begin
                o_cmd.load_pitch = 1'b1;
                n_step = '0;
                n_st = SPitch;
            end
            SPitch: begin
                if (r_step == StepW'(CordicSteps)) begin
                    n_st = SFin;
                end else begin
                    o_cmd.iterate = 1'b1;
                    n_step = r_step + 1'b1;
                end
            end
            SFin: begin
                o_cmd.finish = 1'b1;
                n_st = SIdle;
            end
            default: n_st = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt <= HuntWaitFirst;
            r_cnt <= '0;
            r_st <= SIdle;
            r_step <= '0;
        end else begin
            r_hunt <= n_hunt;
            r_cnt <= n_cnt;
            r_st <= n_st;
            r_step <= n_step;
        end
    end
endmodule

[rtl/aftr_datapath.sv]
// Datapath: body store, checksum, shared CORDIC unit, smoother, counters, result register.
// Depends on aftr_pkg.
module aftr_datapath
    import aftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_store,
    input  logic [2:0] i_store_idx,
    input  logic [7:0] i_byte,
    input  t_cmd       i_cmd,
    input  logic [StepW-1:0] i_step,
    input  logic [8:0] i_alpha,
    input  logic       i_out_take,
    output logic       o_out_valid,
    output logic [183:0] o_out_data
);
    logic [7:0] r_body [0:7];
    logic [55:0] r_last;
    logic r_seen, r_ok, r_valid, r_zero;
    logic signed [CordW-1:0] r_x, r_y;
    logic signed [AngW-1:0] r_ang;
    logic signed [15:0] r_roll, r_pitch, r_sroll, r_spitch;
    logic signed [CordW+17:0] r_prod;
    logic [31:0] r_good, r_bad;

    logic [7:0] sum;
    logic ok_now;
    logic [55:0] frame;
    logic signed [15:0] lastx, sy, sz;
    logic signed [CordW-1:0] ax, ay, lx, ly, shx, shy;
    logic signed [AngW-1:0] la, an;
    logic signed [15:0] ang_out;
    logic [8:0] alpha;
    logic signed [15:0] n_spitch, n_sroll;

    assign sum = r_body[0] + r_body[1] + r_body[2] + r_body[3] + r_body[4]
               + r_body[5] + r_body[6];
    // checksum byte is on the bus in the load cycle
    assign ok_now = (sum == i_byte);
    assign frame = ok_now ? {r_body[6], r_body[5], r_body[4], r_body[3], r_body[2],
                             r_body[1], r_body[0]} : r_last;
    assign lastx = signed'(r_last[23:8]);
    assign sy = signed'(frame[39:24]);
    assign sz = signed'(frame[55:40]);

    // quadrant fold before the micro-rotations
    always_comb begin
        if (i_cmd.load_roll) begin
            ax = CordW'(sz) <<< 8;
            ay = CordW'(sy) <<< 8;
        end else begin
            ax = r_x;
            ay = -(CordW'(lastx) <<< 8);
        end
        lx = ax; ly = ay; la = '0;
        if (ax < 0) begin
            if (ay >= 0) begin
                lx = ay; ly = -ax; la = Deg90Q16;
            end else begin
                lx = -ay; ly = ax; la = -Deg90Q16;
            end
        end
    end

    assign shx = r_x >>> i_step;
    assign shy = r_y >>> i_step;

    function automatic logic signed [15:0] out_angle(input logic signed [AngW-1:0] q,
                                                    input logic signed [15:0] lim);
        logic signed [AngW-1:0] r;
        r = (q + AngW'(1 << (15 - AngleFracBits))) >>> (16 - AngleFracBits);
        if (r > AngW'(lim)) r = AngW'(lim);
        if (r < -AngW'(lim)) r = -AngW'(lim);
        return r[15:0];
    endfunction

    assign ang_out = out_angle(r_ang, i_cmd.save_roll ? 16'sd23040 : 16'sd11520);
    assign alpha = (i_alpha > 9'd256) ? 9'd256 : i_alpha;

    function automatic logic signed [15:0] smooth(input logic signed [15:0] s,
                                                 input logic signed [15:0] a,
                                                 input logic [8:0] al);
        logic signed [27:0] d;
        d = $signed({1'b0, al}) * (28'(a) - 28'(s)) + 28'sd128;
        return s + 16'(d >>> 8);
    endfunction

    assign n_spitch = smooth(r_spitch, ang_out, alpha);
    assign n_sroll = smooth(r_sroll, r_roll, alpha);

    always_ff @(posedge i_clk) begin
        if (i_store) r_body[i_store_idx] <= i_byte;
        if (i_cmd.load_roll || i_cmd.load_pitch) begin
            r_x <= lx; r_y <= ly; r_ang <= la;
            // zero vector keeps angle 0
            r_zero <= (ax == 0) && (ay == 0);
        end else if (i_cmd.iterate) begin
            if (r_y >= 0) begin
                r_x <= r_x + shy; r_y <= r_y - shx;
                if (!r_zero) r_ang <= r_ang + atan_q16(i_step);
            end else begin
                r_x <= r_x - shy; r_y <= r_y + shx;
                if (!r_zero) r_ang <= r_ang - atan_q16(i_step);
            end
        end
        if (i_cmd.save_roll) begin
            r_roll <= ang_out;
            r_prod <= r_x * $signed({1'b0, InvGainQ16});
        end
        if (i_cmd.scale_mag) r_x <= CordW'((r_prod + 46'sd32768) >>> 16);
        if (i_cmd.finish) r_pitch <= ang_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0; r_seen <= 1'b0; r_good <= '0; r_bad <= '0;
            r_spitch <= '0; r_sroll <= '0; r_valid <= 1'b0; r_ok <= 1'b0;
        end else begin
            if (i_out_take) r_valid <= 1'b0;
            if (i_cmd.load_roll) begin
                r_ok <= ok_now;
                r_last <= frame;
            end
            if (i_cmd.finish) begin
                r_valid <= 1'b1;
                if (r_ok) begin
                    r_good <= r_good + 32'd1;
                    r_seen <= 1'b1;
                    r_spitch <= r_seen ? n_spitch : ang_out;
                    r_sroll <= r_seen ? n_sroll : r_roll;
                end else begin
                    r_bad <= r_bad + 32'd1;
                end
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data = {1'b0, r_bad, r_good, r_sroll, r_spitch[14:0], r_roll,
                         r_pitch[14:0], r_last, r_ok};
endmodule

[rtl/accel_frame_tilt_receiver_core.sv]
// Accelerometer frame tilt receiver, top level.
// The closing byte runs two 16-step CORDIC passes on one shared unit, and a new
// byte is taken once that frame's result has left the result register.
// Synchronous active-low reset clears hunt state, counters and smoother.
module accel_frame_tilt_receiver_core
    import aftr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_ok, sequence_res, accel_x, accel_y, accel_z, pitch_now, roll_now,
    // pitch_smoothed, roll_smoothed, good_frames, bad_frames, zero pad
    output logic [183:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [8:0]   i_cfg_wdata
);
    logic [8:0] r_alpha;
    logic take, store;
    logic [2:0] store_idx;
    t_cmd cmd;
    logic [StepW-1:0] step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_alpha <= 9'd46;
        else if (i_cfg_we) r_alpha <= i_cfg_wdata;
    end

    assign take = s_axis_tvalid && s_axis_tready;

    aftr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_byte(s_axis_tdata),
        .i_out_busy(m_axis_tvalid), .o_ready(s_axis_tready), .o_store(store),
        .o_store_idx(store_idx), .o_cmd(cmd), .o_step(step)
    );

    aftr_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_store(store), .i_store_idx(store_idx),
        .i_byte(s_axis_tdata), .i_cmd(cmd), .i_step(step), .i_alpha(r_alpha),
        .i_out_take(m_axis_tvalid && m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_out_data(m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result held");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_roll, cmd.load_pitch, cmd.iterate, cmd.save_roll,
                  cmd.scale_mag, cmd.finish})) else $error("command clash");
`endif
endmodule
